>>> rtl/core/spg_pkg.sv
// ----------------------------------------------------------------------------
// spg_pkg
// Shared types and constants for the score peak grouping table.
// ----------------------------------------------------------------------------
package spg_pkg;

    // Default sizing
    localparam int MAX_CENTERS_DEF = 32;
    localparam int MAX_DIM_DEF     = 1024;

    // Field widths
    localparam int SCORE_W  = 16;
    localparam int COORD_W  = 10;
    localparam int RADIUS_W = 22;
    localparam int MAPDIM_W = 11;
    localparam int ADDR_W   = 4;
    localparam int DATA_W   = 32;

    // Register reset values
    localparam logic [SCORE_W-1:0]  THRESH_RST = 16'h4000;
    localparam logic [RADIUS_W-1:0] RADIUS_RST = 22'd64;
    localparam logic [MAPDIM_W-1:0] WIDTH_RST  = 11'd1024;
    localparam logic [MAPDIM_W-1:0] HEIGHT_RST = 11'd1024;

    // Register index, taken from paddr[3:2]
    typedef enum logic [1:0] {
        REG_THRESH = 2'd0,
        REG_RADIUS = 2'd1,
        REG_WIDTH  = 2'd2,
        REG_HEIGHT = 2'd3
    } reg_idx_t;

    // Configuration seen by the datapath
    typedef struct packed {
        logic [SCORE_W-1:0]  threshold;
        logic [RADIUS_W-1:0] radius_sq;
        logic [MAPDIM_W-1:0] map_width;
        logic [MAPDIM_W-1:0] map_height;
    } cfg_t;

    // Pixel travelling down the cell chain
    typedef struct packed {
        logic               vld;    // slot holds a pixel
        logic               act;    // score above threshold
        logic               taken;  // absorbed or placed by an earlier cell
        logic               last;   // final pixel of the map
        logic [SCORE_W-1:0] score;
        logic [COORD_W-1:0] col;
        logic [COORD_W-1:0] row;
    } pixel_t;

    // Center contents handed toward the head during readout
    typedef struct packed {
        logic               vld;
        logic [COORD_W-1:0] col;
        logic [COORD_W-1:0] row;
    } center_t;

endpackage

>>> rtl/core/spg_cfg.sv
// ----------------------------------------------------------------------------
// spg_cfg
// APB register file: threshold, merge radius and map size.
// ----------------------------------------------------------------------------
module spg_cfg
    import spg_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    output cfg_t              cfg
);

    cfg_t     cfg_reg;
    cfg_t     cfg_next;
    reg_idx_t idx;
    logic     wr_en;

    assign idx    = reg_idx_t'(paddr[3:2]);
    assign wr_en  = psel & penable & pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    // Write decode
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (idx)
                REG_THRESH: cfg_next.threshold  = pwdata[SCORE_W-1:0];
                REG_RADIUS: cfg_next.radius_sq  = pwdata[RADIUS_W-1:0];
                REG_WIDTH:  cfg_next.map_width  = pwdata[MAPDIM_W-1:0];
                REG_HEIGHT: cfg_next.map_height = pwdata[MAPDIM_W-1:0];
                default:    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.threshold  <= THRESH_RST;
            cfg_reg.radius_sq  <= RADIUS_RST;
            cfg_reg.map_width  <= WIDTH_RST;
            cfg_reg.map_height <= HEIGHT_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Read mux
    always_comb
    begin
        unique case (idx)
            REG_THRESH: prdata = {{(DATA_W-SCORE_W){cfg_reg.threshold[SCORE_W-1]}},
                                  cfg_reg.threshold};
            REG_RADIUS: prdata = {{(DATA_W-RADIUS_W){1'b0}}, cfg_reg.radius_sq};
            REG_WIDTH:  prdata = {{(DATA_W-MAPDIM_W){1'b0}}, cfg_reg.map_width};
            REG_HEIGHT: prdata = {{(DATA_W-MAPDIM_W){1'b0}}, cfg_reg.map_height};
            default:    prdata = '0;
        endcase
    end

endmodule

>>> rtl/core/spg_cell.sv
// ----------------------------------------------------------------------------
// spg_cell
// One table entry. Compares the passing pixel with its center, absorbs it,
// or claims it when empty; shifts toward the head during readout.
// ----------------------------------------------------------------------------
module spg_cell
    import spg_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic [RADIUS_W-1:0] radius_sq,
    input  pixel_t              pix_in,
    output pixel_t              pix_out,
    input  logic                shift_en,
    input  center_t             up_in,
    output center_t             cur_out
);

    logic               vld_reg;
    logic               vld_next;
    logic [COORD_W-1:0] col_reg;
    logic [COORD_W-1:0] col_next;
    logic [COORD_W-1:0] row_reg;
    logic [COORD_W-1:0] row_next;
    logic [SCORE_W-1:0] score_reg;
    logic [SCORE_W-1:0] score_next;
    pixel_t             pix_reg;
    pixel_t             pix_next;

    logic signed [COORD_W:0]     dx;
    logic signed [COORD_W:0]     dy;
    logic signed [2*COORD_W+1:0] sq_x;
    logic signed [2*COORD_W+1:0] sq_y;
    logic [2*COORD_W:0]          d2;
    logic                        near;
    logic                        hit;
    logic                        claim;
    logic                        better;

    // Squared distance to the stored center
    assign dx   = $signed({1'b0, col_reg}) - $signed({1'b0, pix_in.col});
    assign dy   = $signed({1'b0, row_reg}) - $signed({1'b0, pix_in.row});
    assign sq_x = dx * dx;
    assign sq_y = dy * dy;
    assign d2   = {1'b0, sq_x[2*COORD_W-1:0]} + {1'b0, sq_y[2*COORD_W-1:0]};
    assign near = {{(RADIUS_W-2*COORD_W-1){1'b0}}, d2} < radius_sq;

    assign hit    = vld_reg & pix_in.vld & pix_in.act & near;
    assign claim  = ~vld_reg & pix_in.vld & pix_in.act & ~pix_in.taken;
    assign better = $signed(pix_in.score) > $signed(score_reg);

    // Center update
    always_comb
    begin
        vld_next   = vld_reg;
        col_next   = col_reg;
        row_next   = row_reg;
        score_next = score_reg;
        if (shift_en)
        begin
            vld_next = up_in.vld;
            col_next = up_in.col;
            row_next = up_in.row;
        end
        else if (claim)
        begin
            vld_next   = 1'b1;
            col_next   = pix_in.col;
            row_next   = pix_in.row;
            score_next = pix_in.score;
        end
        else if (hit && better)
        begin
            col_next   = pix_in.col;
            row_next   = pix_in.row;
            score_next = pix_in.score;
        end
    end

    // Pixel handed to the next cell
    always_comb
    begin
        pix_next       = pix_in;
        pix_next.taken = pix_in.taken | hit | claim;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
            pix_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
            pix_reg <= pix_next;
        end
    end

    always_ff @(posedge clk)
    begin
        col_reg   <= col_next;
        row_reg   <= row_next;
        score_reg <= score_next;
    end

    assign pix_out = pix_reg;
    assign cur_out = '{vld: vld_reg, col: col_reg, row: row_reg};

endmodule

>>> rtl/core/spg_emit.sv
// ----------------------------------------------------------------------------
// spg_emit
// Map sequencing, overflow flag and readout: pulls centers off the chain
// head, drops border centers and drives the output word register.
// ----------------------------------------------------------------------------
module spg_emit
    import spg_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                acc_last,
    input  pixel_t              exit_pix,
    input  center_t             head,
    input  logic [MAPDIM_W-1:0] map_width,
    input  logic [MAPDIM_W-1:0] map_height,
    output logic                in_ready,
    output logic                shift_en,
    output logic                out_valid,
    input  logic                out_ready,
    output logic                found,
    output logic [COORD_W-1:0]  center_col,
    output logic [COORD_W-1:0]  center_row,
    output logic                overflow,
    output logic                is_last
);

    typedef enum logic [1:0] {
        ST_RUN,
        ST_WAIT,
        ST_EMIT
    } state_t;

    state_t             state_reg;
    state_t             state_next;
    logic               ovf_reg;
    logic               ovf_next;
    logic               pend_vld_reg;
    logic               pend_vld_next;
    logic [COORD_W-1:0] pend_col_reg;
    logic [COORD_W-1:0] pend_col_next;
    logic [COORD_W-1:0] pend_row_reg;
    logic [COORD_W-1:0] pend_row_next;
    logic               out_vld_reg;
    logic               out_vld_next;
    logic               found_reg;
    logic               found_next;
    logic [COORD_W-1:0] col_reg;
    logic [COORD_W-1:0] col_next;
    logic [COORD_W-1:0] row_reg;
    logic [COORD_W-1:0] row_next;
    logic               ovf_out_reg;
    logic               ovf_out_next;
    logic               last_reg;
    logic               last_next;

    logic               step;
    logic               inside_map;

    // Output slot free at this edge
    assign step = ~out_vld_reg | out_ready;

    // Center keeps a one-pixel margin from every map edge
    assign inside_map = (head.col != '0) && (head.row != '0)
                     && ({2'b00, head.col} + 12'd2 <= {1'b0, map_width})
                     && ({2'b00, head.row} + 12'd2 <= {1'b0, map_height});

    assign in_ready = (state_reg == ST_RUN);
    assign shift_en = (state_reg == ST_EMIT) & step & head.vld;

    always_comb
    begin
        state_next    = state_reg;
        ovf_next      = ovf_reg;
        pend_vld_next = pend_vld_reg;
        pend_col_next = pend_col_reg;
        pend_row_next = pend_row_reg;
        out_vld_next  = out_vld_reg & ~out_ready;
        found_next    = found_reg;
        col_next      = col_reg;
        row_next      = row_reg;
        ovf_out_next  = ovf_out_reg;
        last_next     = last_reg;

        // New center dropped at the end of a full chain
        if (exit_pix.vld && exit_pix.act && !exit_pix.taken)
        begin
            ovf_next = 1'b1;
        end

        unique case (state_reg)
            ST_RUN:
            begin
                if (acc_last)
                begin
                    state_next = ST_WAIT;
                end
            end
            ST_WAIT:
            begin
                if (exit_pix.vld && exit_pix.last)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (step)
                begin
                    if (head.vld)
                    begin
                        if (inside_map)
                        begin
                            // Previous survivor is known not to be the last
                            if (pend_vld_reg)
                            begin
                                out_vld_next = 1'b1;
                                found_next   = 1'b1;
                                col_next     = pend_col_reg;
                                row_next     = pend_row_reg;
                                ovf_out_next = ovf_reg;
                                last_next    = 1'b0;
                            end
                            pend_vld_next = 1'b1;
                            pend_col_next = head.col;
                            pend_row_next = head.row;
                        end
                    end
                    else
                    begin
                        // Table drained: final word, or the empty result
                        out_vld_next  = 1'b1;
                        found_next    = pend_vld_reg;
                        col_next      = pend_vld_reg ? pend_col_reg : '0;
                        row_next      = pend_vld_reg ? pend_row_reg : '0;
                        ovf_out_next  = ovf_reg;
                        last_next     = 1'b1;
                        pend_vld_next = 1'b0;
                        ovf_next      = 1'b0;
                        state_next    = ST_RUN;
                    end
                end
            end
            default:
            begin
                state_next = ST_RUN;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_RUN;
            ovf_reg      <= 1'b0;
            pend_vld_reg <= 1'b0;
            out_vld_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            ovf_reg      <= ovf_next;
            pend_vld_reg <= pend_vld_next;
            out_vld_reg  <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_col_reg <= pend_col_next;
        pend_row_reg <= pend_row_next;
        found_reg    <= found_next;
        col_reg      <= col_next;
        row_reg      <= row_next;
        ovf_out_reg  <= ovf_out_next;
        last_reg     <= last_next;
    end

    assign out_valid  = out_vld_reg;
    assign found      = found_reg;
    assign center_col = col_reg;
    assign center_row = row_reg;
    assign overflow   = ovf_out_reg;
    assign is_last    = last_reg;

`ifndef NO_ASSERTIONS
    // The end-of-map pixel leaves the chain only while we wait for it
    a_last_exit_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        exit_pix.vld && exit_pix.last |-> state_reg == ST_WAIT)
        else $error("end-of-map pixel left the chain outside ST_WAIT");

    // An empty result is always the final word of its map
    a_empty_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_vld_reg && !found_reg |-> last_reg)
        else $error("empty result without is_last");

    // Finishing readout clears the flag and reopens the input
    a_done_clears: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_EMIT && step && !head.vld
        |=> !ovf_reg && !pend_vld_reg && state_reg == ST_RUN)
        else $error("readout end did not clear map state");
`endif

endmodule

>>> rtl/core/score_peak_grouping_table.sv
// ----------------------------------------------------------------------------
// score_peak_grouping_table
// Greedy radius peak grouping over a raster stream of Q1.15 match scores.
// ----------------------------------------------------------------------------
// Usage:
//   Pixel words (score, col, row, end_of_map) enter on in_valid/in_ready;
//   result words (found, center_col, center_row, overflow, is_last) leave
//   on out_valid/out_ready. The user must write registers over the APB
//   port only while the block is idle; the block itself does not enforce it.
//   A pixel word is taken every cycle while a map streams in. Each word
//   walks the row of MAX_CENTERS table cells, one cell per cycle, through
//   the pixel register of each cell in turn.
//   After the end_of_map word, input stays closed: once the word leaves the
//   last cell, readout starts and moves the table toward the head one entry
//   per cycle while the receiver does not stall. Each result word is
//   registered once the next surviving center, or the drained head, shows
//   whether it is the last; an empty table yields a single word with found
//   low. Input reopens as soon as the final result is in the output register.
//   Reset empties the table, clears the overflow flag and restores the
//   register defaults. A receiver stall holds the output word and freezes
//   the readout; pixel input is not affected by a stall outside readout.
// ----------------------------------------------------------------------------
module score_peak_grouping_table
    import spg_pkg::*;
#(
    parameter int MAX_CENTERS = MAX_CENTERS_DEF,
    parameter int MAX_DIM     = MAX_DIM_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    // APB configuration
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [ADDR_W-1:0]   paddr,
    input  logic [DATA_W-1:0]   pwdata,
    output logic [DATA_W-1:0]   prdata,
    output logic                pready,
    // Pixel input
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [SCORE_W-1:0]  score,
    input  logic [COORD_W-1:0]  col,
    input  logic [COORD_W-1:0]  row,
    input  logic                end_of_map,
    // Result output
    output logic                out_valid,
    input  logic                out_ready,
    output logic                found,
    output logic [COORD_W-1:0]  center_col,
    output logic [COORD_W-1:0]  center_row,
    output logic                overflow,
    output logic                is_last
);

    cfg_t                   cfg;
    pixel_t                 pix_chain [MAX_CENTERS+1];
    center_t                cur_vec   [MAX_CENTERS+1];
    logic [MAX_CENTERS-1:0] vld_vec;
    logic                   accept;
    logic                   shift_en;
    logic [COORD_W-1:0]     col_sat;
    logic [COORD_W-1:0]     row_sat;

    spg_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Input word into the head of the chain
    assign accept  = in_valid & in_ready;
    assign col_sat = (32'(col) >= MAX_DIM) ? COORD_W'(MAX_DIM - 1) : col;
    assign row_sat = (32'(row) >= MAX_DIM) ? COORD_W'(MAX_DIM - 1) : row;

    assign pix_chain[0] = '{vld:   accept,
                            act:   $signed(score) > $signed(cfg.threshold),
                            taken: 1'b0,
                            last:  end_of_map,
                            score: score,
                            col:   col_sat,
                            row:   row_sat};

    // Nothing shifts in behind the tail cell
    assign cur_vec[MAX_CENTERS] = '0;

    // Row of table cells
    for (genvar i = 0; i < MAX_CENTERS; i++)
    begin : g_node
        spg_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .radius_sq (cfg.radius_sq),
            .pix_in    (pix_chain[i]),
            .pix_out   (pix_chain[i+1]),
            .shift_en  (shift_en),
            .up_in     (cur_vec[i+1]),
            .cur_out   (cur_vec[i])
        );
        assign vld_vec[i] = cur_vec[i].vld;
    end

    spg_emit u_emit (
        .clk        (clk),
        .rst_n      (rst_n),
        .acc_last   (accept & end_of_map),
        .exit_pix   (pix_chain[MAX_CENTERS]),
        .head       (cur_vec[0]),
        .map_width  (cfg.map_width),
        .map_height (cfg.map_height),
        .in_ready   (in_ready),
        .shift_en   (shift_en),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .found      (found),
        .center_col (center_col),
        .center_row (center_row),
        .overflow   (overflow),
        .is_last    (is_last)
    );

`ifndef NO_ASSERTIONS
    // Occupied cells always form a prefix of the row, in insertion order
    a_valid_prefix: assert property (@(posedge clk) disable iff (!rst_n)
        ((vld_vec + 1'b1) & vld_vec) == '0)
        else $error("occupied table cells are not a prefix");
`endif

endmodule
